// ===== hdl/mlm_pkg.sv =====
package mlm_pkg;

   localparam int PRODUCT_WIDTH   = 32;
   localparam int KEEP_BITS_WIDTH = 5;
   localparam logic [KEEP_BITS_WIDTH-1:0] KEEP_BITS_RESET = 5'd16;

   // per-operand status passed from the log converter to the antilog stage
   typedef struct packed {
      logic is_zero;
      logic is_minus_one;
      logic sign;
   } mlm_opnd_flags_type;

endpackage

// ===== hdl/mlm_if.sv =====
interface mlm_req_if #(parameter int OPERAND_WIDTH = 16);
   logic                            valid;
   logic                            ready;
   logic signed [OPERAND_WIDTH-1:0] operand_a;
   logic signed [OPERAND_WIDTH-1:0] operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface mlm_rsp_if
   import mlm_pkg::*;
();
   logic                            valid;
   logic                            ready;
   logic signed [PRODUCT_WIDTH-1:0] product;

   modport source (output valid, output product, input ready);
   modport sink   (input valid, input product, output ready);
endinterface

// ===== hdl/mlm_log_conv.sv =====
module mlm_log_conv
   import mlm_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic signed [OPERAND_WIDTH-1:0]         operand,
   input  logic [OPERAND_WIDTH-2:0]                keep_mask,
   output mlm_opnd_flags_type                      flags,
   output logic [$clog2(OPERAND_WIDTH)-1:0]        characteristic,
   output logic [OPERAND_WIDTH-2:0]                fraction
);

   localparam int CW = $clog2(OPERAND_WIDTH);

   logic [OPERAND_WIDTH-1:0] mag;
   logic [OPERAND_WIDTH-1:0] norm;
   logic [CW-1:0]            lead;
   logic [CW-1:0]            shamt;

   // one's complement of negatives; sign bit of mag is then always clear
   assign mag = operand[OPERAND_WIDTH-1] ? ~operand : operand;

   always_comb begin
      lead = '0;
      for (int i = 0; i < OPERAND_WIDTH; i++) begin
         if (mag[i]) begin
            lead = CW'(i);
         end
      end
   end

   assign shamt          = CW'(OPERAND_WIDTH - 1) - lead;
   assign norm           = mag << shamt;
   assign characteristic = lead;
   assign fraction       = norm[OPERAND_WIDTH-2:0] & keep_mask;

   assign flags.is_zero      = (operand == '0);
   assign flags.is_minus_one = &operand;
   assign flags.sign         = operand[OPERAND_WIDTH-1];

endmodule

// ===== hdl/mlm_antilog.sv =====
module mlm_antilog
   import mlm_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  mlm_opnd_flags_type                  flags_a,
   input  mlm_opnd_flags_type                  flags_b,
   input  logic [$clog2(OPERAND_WIDTH)-1:0]    char_a,
   input  logic [$clog2(OPERAND_WIDTH)-1:0]    char_b,
   input  logic [OPERAND_WIDTH-2:0]            frac_a,
   input  logic [OPERAND_WIDTH-2:0]            frac_b,
   input  logic signed [OPERAND_WIDTH-1:0]     operand_a,
   input  logic signed [OPERAND_WIDTH-1:0]     operand_b,
   output logic signed [PRODUCT_WIDTH-1:0]     product
);

   localparam int FB  = OPERAND_WIDTH - 1;
   localparam int KLW = $clog2(2 * OPERAND_WIDTH);
   // mantissa shifted left by up to 2W-3, wide enough to pick 32 bits above FB
   localparam int EW  = (3 * OPERAND_WIDTH - 3 > FB + PRODUCT_WIDTH) ?
                        3 * OPERAND_WIDTH - 3 : FB + PRODUCT_WIDTH;

   logic [OPERAND_WIDTH-1:0]        frac_sum;
   logic [KLW-1:0]                  char_sum;
   logic [OPERAND_WIDTH-1:0]        mant;
   logic [EW-1:0]                   wide;
   logic [PRODUCT_WIDTH-1:0]        pabs;
   logic signed [PRODUCT_WIDTH-1:0] ext_a;
   logic signed [PRODUCT_WIDTH-1:0] ext_b;

   assign frac_sum = {1'b0, frac_a} + {1'b0, frac_b};
   assign char_sum = KLW'(char_a) + KLW'(char_b) + KLW'(frac_sum[FB]);
   assign mant     = {1'b1, frac_sum[FB-1:0]};
   // (mant << k) >> FB, truncating
   assign wide     = EW'(mant) << char_sum;
   assign pabs     = wide[FB+PRODUCT_WIDTH-1:FB];

   assign ext_a = PRODUCT_WIDTH'(operand_a);
   assign ext_b = PRODUCT_WIDTH'(operand_b);

   always_comb begin
      if (flags_a.is_zero || flags_b.is_zero) begin
         product = '0;
      end else if (flags_a.is_minus_one) begin
         product = -ext_b;
      end else if (flags_b.is_minus_one) begin
         product = -ext_a;
      end else begin
         product = pabs ^ {PRODUCT_WIDTH{flags_a.sign ^ flags_b.sign}};
      end
   end

endmodule

// ===== hdl/mitchell_log_multiplier_truncated.sv =====
// Channel  Dir  Payload                          Beat taken when
// req_bus  in   operand_a, operand_b (signed W)  valid && ready
// rsp_bus  out  product (signed 32)              valid && ready
// csr      in   keep_bits (5 bits)               csr_write_enable
//
// Two register stages: operands are registered on entry, the product is
// registered on exit, with the log/antilog logic between them. One beat per
// cycle is sustained while rsp_bus.ready is high. A stalled result holds in
// the output register; a new beat still enters the operand register if empty.
// Synchronous reset clears both valids and sets keep_bits to 16.
module mitchell_log_multiplier_truncated
   import mlm_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   mlm_req_if.sink                    req_bus,
   mlm_rsp_if.source                  rsp_bus,
   input  logic                       csr_write_enable,
   input  logic [KEEP_BITS_WIDTH-1:0] csr_write_data
);

   localparam int CW = $clog2(OPERAND_WIDTH);
   localparam int KW = $clog2(OPERAND_WIDTH + 1);

   logic [KEEP_BITS_WIDTH-1:0]      keep_bits_ff;
   logic [KEEP_BITS_WIDTH-1:0]      keep_bits_in;
   logic [KW-1:0]                   keep_sat;
   logic [OPERAND_WIDTH-2:0]        keep_mask;

   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   logic signed [OPERAND_WIDTH-1:0] op_a_ff;
   logic signed [OPERAND_WIDTH-1:0] op_a_in;
   logic signed [OPERAND_WIDTH-1:0] op_b_ff;
   logic signed [OPERAND_WIDTH-1:0] op_b_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic signed [PRODUCT_WIDTH-1:0] product_ff;
   logic signed [PRODUCT_WIDTH-1:0] product_in;
   logic                            s1_ready;
   logic                            s2_ready;

   mlm_opnd_flags_type              flags_a;
   mlm_opnd_flags_type              flags_b;
   logic [CW-1:0]                   char_a;
   logic [CW-1:0]                   char_b;
   logic [OPERAND_WIDTH-2:0]        frac_a;
   logic [OPERAND_WIDTH-2:0]        frac_b;
   logic signed [PRODUCT_WIDTH-1:0] product_calc;

   // keep_bits clamped to 1..W
   always_comb begin
      if (keep_bits_ff == '0) begin
         keep_sat = KW'(1);
      end else if (6'(keep_bits_ff) > 6'(OPERAND_WIDTH)) begin
         keep_sat = KW'(OPERAND_WIDTH);
      end else begin
         keep_sat = KW'(keep_bits_ff);
      end
   end

   // fraction bit i survives when i >= W - keep
   always_comb begin
      for (int i = 0; i < OPERAND_WIDTH - 1; i++) begin
         keep_mask[i] = (KW'(OPERAND_WIDTH - 1 - i) < keep_sat);
      end
   end

   assign keep_bits_in = csr_write_enable ? csr_write_data : keep_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_bits_ff <= KEEP_BITS_RESET;
      end else begin
         keep_bits_ff <= keep_bits_in;
      end
   end

   assign s2_ready      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_ready      = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;

   always_comb begin
      s1_valid_in  = s1_ready ? req_bus.valid : s1_valid_ff;
      op_a_in      = (s1_ready && req_bus.valid) ? req_bus.operand_a : op_a_ff;
      op_b_in      = (s1_ready && req_bus.valid) ? req_bus.operand_b : op_b_ff;
      rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;
      product_in   = (s2_ready && s1_valid_ff) ? product_calc : product_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_a_ff    <= op_a_in;
      op_b_ff    <= op_b_in;
      product_ff <= product_in;
   end

   mlm_log_conv #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_conv_a (
      .operand        (op_a_ff),
      .keep_mask      (keep_mask),
      .flags          (flags_a),
      .characteristic (char_a),
      .fraction       (frac_a)
   );

   mlm_log_conv #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_conv_b (
      .operand        (op_b_ff),
      .keep_mask      (keep_mask),
      .flags          (flags_b),
      .characteristic (char_b),
      .fraction       (frac_b)
   );

   mlm_antilog #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_antilog (
      .flags_a   (flags_a),
      .flags_b   (flags_b),
      .char_a    (char_a),
      .char_b    (char_b),
      .frac_a    (frac_a),
      .frac_b    (frac_b),
      .operand_a (op_a_ff),
      .operand_b (op_b_ff),
      .product   (product_calc)
   );

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.product = product_ff;

   a_input_free: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_bus.ready)
      else $error("input stage empty but not ready");

   a_beat_advances: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_ready |=> rsp_bus.valid)
      else $error("beat lost between stages");

   a_zero_operand: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_ready && (op_a_ff == '0 || op_b_ff == '0)
      |=> rsp_bus.product == '0)
      else $error("zero operand gave nonzero product");

   a_minus_one: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_ready && (&op_a_ff)
      |=> rsp_bus.product == -$past(PRODUCT_WIDTH'(op_b_ff)))
      else $error("minus one operand not exact negation");

endmodule
